>>> design/ofi_pkg.sv
// Shared types and constants of the orientation frame interpolator.
// Depends on nothing; every design file refers to it by scoped names.
package ofi_pkg;

    localparam int COMPONENT_BITS        = 16;
    localparam int FRACTION_BITS_DEFAULT = 14;
    localparam int VEC_BITS              = 3 * COMPONENT_BITS;
    localparam int BLEND_BITS            = 16;
    localparam int BLEND_ONE             = 32768;
    localparam int MIN_LENGTH_BITS       = 16;
    localparam logic [MIN_LENGTH_BITS-1:0] MIN_LENGTH_RESET = 16'd2;
    // Normalization window: the largest magnitude is brought into [2^29, 2^30).
    localparam int WIN_BITS              = 30;

    typedef struct packed {
        logic [VEC_BITS-1:0]   a_direction;
        logic [VEC_BITS-1:0]   a_upward;
        logic [VEC_BITS-1:0]   b_direction;
        logic [VEC_BITS-1:0]   b_upward;
        logic [BLEND_BITS-1:0] blend;
    } t_in_item;

    typedef struct packed {
        logic [VEC_BITS-1:0] out_direction;
        logic [VEC_BITS-1:0] out_upward;
        logic                direction_fell_back;
        logic                upward_fell_back;
        logic                upward_degenerate;
    } t_out_item;

endpackage

>>> design/orientation_frame_interpolator.sv
// Top level of the orientation frame interpolator: blend, fallback, orthogonalize.
// Depends on ofi_pkg and instantiates ofi_normalize three times.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one item: two frames, each a
//   packed direction and up vector in signed Q2.14, and a Q1.15 blend factor.
//   Output channel (o_out_valid / i_out_ready) returns exactly one result item
//   per input item, in order: unit direction, orthonormal up and three flags.
//   Configuration channel (i_cfg_valid / o_cfg_ready) writes min_length; it is
//   always ready. The user must write it only while no item is in flight; the
//   block itself does not enforce this.
// Throughput: one item per cycle while the receiver does not hold off.
// Depth: two normalizer passes in series, each a 31-stage square root plus a
//   (FRACTION_BITS+1)-stage divider.
// Reset: synchronous, active low; empties the pipeline and sets min_length to 2.
// Stall: when the receiver holds off, the result waits in the output register
//   and the pipeline keeps accepting until an item reaches its last stage; then
//   the whole pipeline holds and o_in_ready drops. Nothing is lost or repeated.
module orientation_frame_interpolator #(
    parameter int FRACTION_BITS = ofi_pkg::FRACTION_BITS_DEFAULT
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  ofi_pkg::t_in_item                     i_in_item,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output ofi_pkg::t_out_item                    o_out_item,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [ofi_pkg::MIN_LENGTH_BITS-1:0]   i_cfg_data
);

    localparam int CB  = ofi_pkg::COMPONENT_BITS;
    localparam int VB  = ofi_pkg::VEC_BITS;
    localparam int BW  = CB + 1;            // blended component width
    localparam int PB  = 34;                // blend product width
    localparam int H   = CB + 1;            // low split of dd and du
    localparam int WW  = 3 * CB + 2;        // orthogonalized component width
    localparam int ML  = ofi_pkg::MIN_LENGTH_BITS;
    localparam logic [2*ML-1:0] MIN_SQ_RESET =
        (2*ML)'(ofi_pkg::MIN_LENGTH_RESET) * (2*ML)'(ofi_pkg::MIN_LENGTH_RESET);

    function automatic logic signed [CB-1:0] comp(input logic [VB-1:0] v, input int idx);
        return $signed(v[idx*CB +: CB]);
    endfunction

    logic en;

    // Configuration
    logic [ML-1:0]   r_min_len;
    logic [2*ML-1:0] r_min_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_len <= ofi_pkg::MIN_LENGTH_RESET;
            r_min_sq  <= MIN_SQ_RESET;
        end else begin
            if (i_cfg_valid) begin
                r_min_len <= i_cfg_data;
            end
            r_min_sq <= (2*ML)'(r_min_len) * (2*ML)'(r_min_len);
        end
    end
    assign o_cfg_ready = 1'b1;

    // Front valid bits: input register, products, blend, squares, select.
    logic r_v0, r_v1, r_v2, r_v3, r_v4;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            {r_v0, r_v1, r_v2, r_v3, r_v4} <= '0;
        end else if (en) begin
            {r_v0, r_v1, r_v2, r_v3, r_v4} <= {i_in_valid, r_v0, r_v1, r_v2, r_v3};
        end
    end

    ofi_pkg::t_in_item r_in;
    logic [VB-1:0] r_ad1, r_au1, r_ad2, r_au2, r_ad3, r_au3;
    // Index 0..2 direction, 3..5 up.
    logic signed [PB-1:0] r_pa [6];
    logic signed [PB-1:0] r_pb [6];
    logic signed [BW-1:0] r_bv2 [6];
    logic signed [BW-1:0] r_bv3 [6];
    logic signed [PB-1:0] r_sq3 [6];
    logic [3*BW-1:0] r_sel_d, r_sel_u;
    logic            r_dfb4, r_ufb4;

    // Clamp blend above one; weights for a and b.
    logic [16:0] f_b, f_a;
    always_comb begin
        f_b = (17'(r_in.blend) > 17'(ofi_pkg::BLEND_ONE)) ? 17'(ofi_pkg::BLEND_ONE)
                                                          : 17'(r_in.blend);
        f_a = 17'(ofi_pkg::BLEND_ONE) - f_b;
    end

    // Round t / 32768 to nearest, ties away from zero.
    logic signed [BW-1:0] n_bv [6];
    always_comb begin
        logic signed [PB-1:0] t;
        logic [PB-1:0]        m;
        logic [PB-1:0]        r;
        for (int i = 0; i < 6; i++) begin
            t       = r_pa[i] + r_pb[i];
            m       = t[PB-1] ? PB'(-t) : PB'(t);
            r       = (m + PB'(1 << 14)) >> 15;
            n_bv[i] = t[PB-1] ? BW'(-$signed(r)) : BW'($signed(r));
        end
    end

    // Short test and fallback select.
    logic [PB+1:0]   sum_d, sum_u;
    logic            n_dfb, n_ufb;
    logic [3*BW-1:0] n_sel_d, n_sel_u;
    always_comb begin
        sum_d = (PB+2)'(unsigned'(r_sq3[0])) + (PB+2)'(unsigned'(r_sq3[1]))
              + (PB+2)'(unsigned'(r_sq3[2]));
        sum_u = (PB+2)'(unsigned'(r_sq3[3])) + (PB+2)'(unsigned'(r_sq3[4]))
              + (PB+2)'(unsigned'(r_sq3[5]));
        n_dfb = sum_d < (PB+2)'(r_min_sq);
        n_ufb = sum_u < (PB+2)'(r_min_sq);
        for (int i = 0; i < 3; i++) begin
            n_sel_d[i*BW +: BW] = n_dfb ? BW'(comp(r_ad3, i)) : r_bv3[i];
            n_sel_u[i*BW +: BW] = n_ufb ? BW'(comp(r_au3, i)) : r_bv3[i+3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in <= i_in_item;
            r_ad1 <= r_in.a_direction;
            r_au1 <= r_in.a_upward;
            for (int i = 0; i < 3; i++) begin
                r_pa[i]   <= PB'(comp(r_in.a_direction, i)) * PB'($signed({1'b0, f_a}));
                r_pb[i]   <= PB'(comp(r_in.b_direction, i)) * PB'($signed({1'b0, f_b}));
                r_pa[i+3] <= PB'(comp(r_in.a_upward, i)) * PB'($signed({1'b0, f_a}));
                r_pb[i+3] <= PB'(comp(r_in.b_upward, i)) * PB'($signed({1'b0, f_b}));
            end
            r_ad2 <= r_ad1;
            r_au2 <= r_au1;
            r_bv2 <= n_bv;
            r_ad3 <= r_ad2;
            r_au3 <= r_au2;
            r_bv3 <= r_bv2;
            for (int i = 0; i < 6; i++) begin
                r_sq3[i] <= PB'(r_bv2[i]) * PB'(r_bv2[i]);
            end
            r_sel_d <= n_sel_d;
            r_sel_u <= n_sel_u;
            r_dfb4  <= n_dfb;
            r_ufb4  <= n_ufb;
        end
    end

    // Normalize blended direction and up side by side.
    logic          d_valid, d_fb, u_fb;
    logic [VB-1:0] d_vec, u_vec;

    ofi_normalize #(
        .IN_W          (BW),
        .SIDE_W        (1),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_norm_dir (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (r_v4),
        .i_vec     (r_sel_d),
        .i_side    (r_dfb4),
        .o_valid   (d_valid),
        .o_nonzero (),
        .o_vec     (d_vec),
        .o_side    (d_fb)
    );

    ofi_normalize #(
        .IN_W          (BW),
        .SIDE_W        (1),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_norm_up (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (r_v4),
        .i_vec     (r_sel_u),
        .i_side    (r_ufb4),
        .o_valid   (),
        .o_nonzero (),
        .o_vec     (u_vec),
        .o_side    (u_fb)
    );

    // Orthogonalize: w = u*(d.d) - d*(d.u), products split at bit H.
    logic r_qv1, r_qv2, r_qv3, r_qv4;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            {r_qv1, r_qv2, r_qv3, r_qv4} <= '0;
        end else if (en) begin
            {r_qv1, r_qv2, r_qv3, r_qv4} <= {d_valid, r_qv1, r_qv2, r_qv3};
        end
    end

    logic [VB-1:0]          r_d1, r_u1, r_d2, r_u2, r_d3, r_d4;
    logic [1:0]             r_fb1, r_fb2, r_fb3, r_fb4;
    logic signed [2*CB-1:0] r_ddp [3];
    logic signed [2*CB-1:0] r_dup [3];
    logic signed [2*CB:0]   r_dd, r_du;
    logic signed [2*CB-1:0] r_uh [3];
    logic signed [2*CB+1:0] r_ul [3];
    logic signed [2*CB-1:0] r_dh [3];
    logic signed [2*CB+1:0] r_dlo [3];
    logic [3*WW-1:0]        r_w;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d1  <= d_vec;
            r_u1  <= u_vec;
            r_fb1 <= {d_fb, u_fb};
            for (int i = 0; i < 3; i++) begin
                r_ddp[i] <= (2*CB)'(comp(d_vec, i)) * (2*CB)'(comp(d_vec, i));
                r_dup[i] <= (2*CB)'(comp(d_vec, i)) * (2*CB)'(comp(u_vec, i));
            end
            r_d2  <= r_d1;
            r_u2  <= r_u1;
            r_fb2 <= r_fb1;
            r_dd  <= (2*CB+1)'(r_ddp[0]) + (2*CB+1)'(r_ddp[1]) + (2*CB+1)'(r_ddp[2]);
            r_du  <= (2*CB+1)'(r_dup[0]) + (2*CB+1)'(r_dup[1]) + (2*CB+1)'(r_dup[2]);
            r_d3  <= r_d2;
            r_fb3 <= r_fb2;
            for (int i = 0; i < 3; i++) begin
                r_uh[i]  <= (2*CB)'(comp(r_u2, i)) * (2*CB)'($signed(r_dd[2*CB:H]));
                r_ul[i]  <= (2*CB+2)'(comp(r_u2, i)) * (2*CB+2)'($signed({1'b0, r_dd[H-1:0]}));
                r_dh[i]  <= (2*CB)'(comp(r_d2, i)) * (2*CB)'($signed(r_du[2*CB:H]));
                r_dlo[i] <= (2*CB+2)'(comp(r_d2, i)) * (2*CB+2)'($signed({1'b0, r_du[H-1:0]}));
            end
            r_d4  <= r_d3;
            r_fb4 <= r_fb3;
            for (int i = 0; i < 3; i++) begin
                r_w[i*WW +: WW] <= (WW'(r_uh[i]) <<< H) + WW'(r_ul[i])
                                 - (WW'(r_dh[i]) <<< H) - WW'(r_dlo[i]);
            end
        end
    end

    // Normalize w; direction and flags ride along.
    logic            w_valid, w_nonzero;
    logic [VB-1:0]   w_vec;
    logic [VB+1:0]   w_side;

    ofi_normalize #(
        .IN_W          (WW),
        .SIDE_W        (VB + 2),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_norm_ortho (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (r_qv4),
        .i_vec     (r_w),
        .i_side    ({r_d4, r_fb4}),
        .o_valid   (w_valid),
        .o_nonzero (w_nonzero),
        .o_vec     (w_vec),
        .o_side    (w_side)
    );

    // Output register; advance the pipeline unless a finished item would be blocked.
    logic r_out_valid;
    ofi_pkg::t_out_item r_out;

    assign en = !w_valid || !r_out_valid || i_out_ready;

    // Load a finished item; otherwise hold the waiting result until it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en && w_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && w_valid) begin
            r_out.out_direction       <= w_side[VB+1:2];
            r_out.out_upward          <= w_vec;
            r_out.direction_fell_back <= w_side[1];
            r_out.upward_fell_back    <= w_side[0];
            r_out.upward_degenerate   <= !w_nonzero;
        end
    end

    assign o_in_ready  = en;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Checks
    a_degenerate_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.upward_degenerate) |-> (o_out_item.out_upward == '0))
        else $error("degenerate up is not zero");

    a_dir_no_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.out_direction[CB-1:0] != {1'b1, {(CB-1){1'b0}}}
                      && o_out_item.out_direction[2*CB-1:CB] != {1'b1, {(CB-1){1'b0}}}
                      && o_out_item.out_direction[3*CB-1:2*CB] != {1'b1, {(CB-1){1'b0}}}))
        else $error("direction component escaped the clamp");

    a_up_no_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.out_upward[CB-1:0] != {1'b1, {(CB-1){1'b0}}}
                      && o_out_item.out_upward[2*CB-1:CB] != {1'b1, {(CB-1){1'b0}}}
                      && o_out_item.out_upward[3*CB-1:2*CB] != {1'b1, {(CB-1){1'b0}}}))
        else $error("up component escaped the clamp");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready && w_valid))
        else $error("input held off without a blocked result");

endmodule

>>> design/ofi_normalize.sv
// Pipelined vector normalizer: window shift, sum of squares, square root, divide.
// Depends on ofi_pkg for the component format and window width.
module ofi_normalize #(
    parameter int IN_W          = 17,
    parameter int SIDE_W        = 1,
    parameter int FRACTION_BITS = ofi_pkg::FRACTION_BITS_DEFAULT
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_valid,
    input  logic [3*IN_W-1:0]                    i_vec,
    input  logic [SIDE_W-1:0]                    i_side,
    output logic                                 o_valid,
    output logic                                 o_nonzero,
    output logic [3*ofi_pkg::COMPONENT_BITS-1:0] o_vec,
    output logic [SIDE_W-1:0]                    o_side
);

    localparam int CB    = ofi_pkg::COMPONENT_BITS;
    localparam int WB    = ofi_pkg::WIN_BITS;
    localparam int MW    = IN_W;
    localparam int PW    = $clog2(MW);
    localparam int SW    = MW + WB;
    localparam int SQ_W  = 2 * WB;
    localparam int SUM_W = SQ_W + 2;
    localparam int RT_W  = SUM_W / 2;
    localparam int RM_W  = RT_W + 2;
    localparam int QW    = FRACTION_BITS + 1;
    localparam int NW    = WB + FRACTION_BITS + 1;
    localparam int LAT   = 5 + RT_W + 1 + QW + 1;
    localparam int TAG_W = 4 + SIDE_W;
    localparam int CW    = (QW > CB) ? QW : CB;
    localparam logic [CW-1:0] COMP_MAX = CW'((1 << (CB - 1)) - 1);

    logic [LAT-1:0]   r_vld;
    logic [TAG_W-1:0] r_tag [LAT];
    logic [TAG_W-1:0] n_tag;

    logic [MW-1:0]    n_m0 [3];
    logic [MW-1:0]    r_m0 [3];
    logic [MW-1:0]    r_m1 [3];
    logic [PW-1:0]    n_pos;
    logic [PW-1:0]    r_pos;
    logic [WB-1:0]    n_w2 [3];
    logic [WB-1:0]    r_w2 [3];
    logic [SQ_W-1:0]  r_sq3 [3];
    logic [WB-1:0]    r_w3 [3];

    logic [SUM_W-1:0] r_sn [RT_W+1];
    logic [RM_W-1:0]  r_sr [RT_W+1];
    logic [RT_W-1:0]  r_st [RT_W+1];
    logic [WB-1:0]    r_sw [RT_W+1][3];

    logic [RT_W-1:0]  r_dl [QW+1];
    logic [RT_W-1:0]  r_dr [QW+1][3];
    logic [QW-1:0]    r_dx [QW+1][3];

    logic [3*CB-1:0]  n_vec;
    logic [3*CB-1:0]  r_vec;

    // Magnitudes, signs and zero test of the incoming vector.
    always_comb begin
        logic signed [IN_W-1:0] c;
        logic [2:0]             sg;
        n_tag = '0;
        sg    = '0;
        for (int i = 0; i < 3; i++) begin
            c       = $signed(i_vec[i*IN_W +: IN_W]);
            sg[i]   = c[IN_W-1];
            n_m0[i] = sg[i] ? MW'(-c) : MW'(c);
        end
        n_tag = {i_side, (|i_vec), sg};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag[0] <= n_tag;
            for (int k = 1; k < LAT; k++) begin
                r_tag[k] <= r_tag[k-1];
            end
        end
    end

    // Leading one of the OR of magnitudes is the leading one of the largest.
    always_comb begin
        logic [MW-1:0] orv;
        orv   = r_m0[0] | r_m0[1] | r_m0[2];
        n_pos = '0;
        for (int b = 0; b < MW; b++) begin
            if (orv[b]) begin
                n_pos = PW'(b);
            end
        end
    end

    // Shift all magnitudes by one amount into the window; right shifts truncate.
    always_comb begin
        logic [SW-1:0] ext;
        logic [SW-1:0] sh;
        for (int i = 0; i < 3; i++) begin
            ext = SW'(r_m1[i]);
            if (int'(r_pos) >= WB - 1) begin
                sh = ext >> (int'(r_pos) - (WB - 1));
            end else begin
                sh = ext << ((WB - 1) - int'(r_pos));
            end
            n_w2[i] = sh[WB-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m0  <= n_m0;
            r_m1  <= r_m0;
            r_pos <= n_pos;
            r_w2  <= n_w2;
            for (int i = 0; i < 3; i++) begin
                r_sq3[i] <= SQ_W'(r_w2[i]) * SQ_W'(r_w2[i]);
            end
            r_w3    <= r_w2;
            r_sn[0] <= SUM_W'(r_sq3[0]) + SUM_W'(r_sq3[1]) + SUM_W'(r_sq3[2]);
            r_sr[0] <= '0;
            r_st[0] <= '0;
            r_sw[0] <= r_w3;
        end
    end

    // Square root, one result bit per stage.
    for (genvar k = 1; k <= RT_W; k++) begin : g_sqrt
        logic [RM_W+1:0] rem_sh;
        logic [RM_W+1:0] trial;
        logic            take;
        assign rem_sh = {r_sr[k-1], r_sn[k-1][SUM_W-1 -: 2]};
        assign trial  = (RM_W + 2)'({r_st[k-1], 2'b01});
        assign take   = rem_sh >= trial;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sn[k] <= r_sn[k-1] << 2;
                r_sr[k] <= take ? RM_W'(rem_sh - trial) : RM_W'(rem_sh);
                r_st[k] <= {r_st[k-1][RT_W-2:0], take};
                r_sw[k] <= r_sw[k-1];
            end
        end
    end

    // Rounded dividend; its upper part seeds the remainder.
    always_ff @(posedge i_clk) begin
        logic [NW-1:0] num;
        if (i_en) begin
            r_dl[0] <= r_st[RT_W];
            for (int i = 0; i < 3; i++) begin
                num = (NW'(r_sw[RT_W][i]) << FRACTION_BITS) + NW'(r_st[RT_W] >> 1);
                r_dr[0][i] <= RT_W'(num >> QW);
                r_dx[0][i] <= num[QW-1:0];
            end
        end
    end

    // Restoring division, one quotient bit per stage for each component.
    for (genvar k = 1; k <= QW; k++) begin : g_div
        always_ff @(posedge i_clk) begin
            logic [RT_W:0] rem2;
            logic          take;
            if (i_en) begin
                r_dl[k] <= r_dl[k-1];
                for (int i = 0; i < 3; i++) begin
                    rem2 = {r_dr[k-1][i], r_dx[k-1][i][QW-1]};
                    take = rem2 >= {1'b0, r_dl[k-1]};
                    r_dr[k][i] <= take ? RT_W'(rem2 - {1'b0, r_dl[k-1]}) : RT_W'(rem2);
                    r_dx[k][i] <= {r_dx[k-1][i][QW-2:0], take};
                end
            end
        end
    end

    // Clamp, restore the sign, force zero for a zero input.
    always_comb begin
        logic [CW-1:0]          q;
        logic signed [CB-1:0]   s;
        logic [TAG_W-1:0]       t;
        t = r_tag[LAT-2];
        for (int i = 0; i < 3; i++) begin
            q = CW'(r_dx[QW][i]);
            s = (q > COMP_MAX) ? CB'(COMP_MAX) : CB'(q);
            if (!t[3]) begin
                s = '0;
            end else if (t[i]) begin
                s = -s;
            end
            n_vec[i*CB +: CB] = s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vec <= n_vec;
        end
    end

    assign o_valid   = r_vld[LAT-1];
    assign o_nonzero = r_tag[LAT-1][3];
    assign o_side    = r_tag[LAT-1][TAG_W-1:4];
    assign o_vec     = r_vec;

endmodule

>>> tb/ofi_frame_checker.sv
`timescale 1ns / 100ps
// Checker for the orientation frame interpolator: watches the item, result and
// min_length channels, predicts each result and compares it. Depends on ofi_pkg.
module ofi_frame_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  ofi_pkg::t_in_item                   i_in_item,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  ofi_pkg::t_out_item                  i_out_item,
    input  logic                                i_cfg_valid,
    input  logic                                i_cfg_ready,
    input  logic [ofi_pkg::MIN_LENGTH_BITS-1:0] i_cfg_data,
    output int                                  o_mismatches,
    output int                                  o_pending
);
    import ofi_pkg::*;

    localparam int FRAC = FRACTION_BITS_DEFAULT;
    localparam longint COMP_LIMIT = (64'sd1 << (COMPONENT_BITS - 1)) - 1;

    typedef longint triple_t [3];

    logic [MIN_LENGTH_BITS-1:0] min_length_q;
    t_out_item                  expected_frames [$];

    function automatic longint unsigned mag(longint x);
        return (x < 0) ? longint'(-x) : longint'(x);
    endfunction

    function automatic void unpack_vec(logic [VEC_BITS-1:0] raw, output triple_t v);
        for (int i = 0; i < 3; i++)
            v[i] = longint'(signed'(raw[i*COMPONENT_BITS +: COMPONENT_BITS]));
    endfunction

    function automatic logic [VEC_BITS-1:0] pack_vec(triple_t v);
        logic [VEC_BITS-1:0] r;
        for (int i = 0; i < 3; i++)
            r[i*COMPONENT_BITS +: COMPONENT_BITS] = v[i][COMPONENT_BITS-1:0];
        return r;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res, b;
        res = 0;
        b   = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n   = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Scale to unit length; returns 0 for the zero vector.
    function automatic bit unit_vec(triple_t v, output triple_t o);
        longint unsigned m [3];
        longint unsigned big, total, len, q;
        longint          s;
        big = 0;
        total = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = mag(v[i]);
            if (m[i] > big) big = m[i];
        end
        if (big == 0) begin
            o = '{0, 0, 0};
            return 0;
        end
        while (big < (64'd1 << 29)) begin
            big = big << 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
        end
        while (big >= (64'd1 << 30)) begin
            big = big >> 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
        end
        for (int i = 0; i < 3; i++) total += m[i] * m[i];
        len = int_sqrt(total);
        for (int i = 0; i < 3; i++) begin
            q = ((m[i] << FRAC) + len / 2) / len;
            s = (q > COMP_LIMIT) ? COMP_LIMIT : longint'(q);
            o[i] = (v[i] < 0) ? -s : s;
        end
        return 1;
    endfunction

    // Blend two vectors and normalize; returns 1 when frame a was taken instead.
    function automatic bit blend_unit(triple_t a, triple_t b, longint f, output triple_t o);
        triple_t         v;
        longint          t;
        longint unsigned r, sq;
        bit              nz;
        sq = 0;
        for (int i = 0; i < 3; i++) begin
            t = a[i] * (BLEND_ONE - f) + b[i] * f;
            r = (mag(t) + (64'd1 << 14)) >> 15;
            v[i] = (t < 0) ? -longint'(r) : longint'(r);
            sq += mag(v[i]) * mag(v[i]);
        end
        if (sq < longint'(min_length_q) * longint'(min_length_q)) begin
            nz = unit_vec(a, o);
            return 1;
        end
        nz = unit_vec(v, o);
        return 0;
    endfunction

    function automatic t_out_item predict_frame(t_in_item it);
        triple_t   ad, au, bd, bu, d, u, w, up;
        longint    f, dd, du;
        t_out_item r;
        f = longint'(it.blend);
        if (f > BLEND_ONE) f = BLEND_ONE;
        unpack_vec(it.a_direction, ad);
        unpack_vec(it.a_upward, au);
        unpack_vec(it.b_direction, bd);
        unpack_vec(it.b_upward, bu);
        r.direction_fell_back = blend_unit(ad, bd, f, d);
        r.upward_fell_back    = blend_unit(au, bu, f, u);
        dd = d[0]*d[0] + d[1]*d[1] + d[2]*d[2];
        du = d[0]*u[0] + d[1]*u[1] + d[2]*u[2];
        for (int i = 0; i < 3; i++) w[i] = u[i] * dd - d[i] * du;
        r.upward_degenerate = !unit_vec(w, up);
        r.out_direction = pack_vec(d);
        r.out_upward    = pack_vec(up);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        int        errs;
        errs = 0;
        if (!i_rst_n) begin
            min_length_q <= MIN_LENGTH_RESET;
            expected_frames.delete();
            o_mismatches <= 0;
            o_pending    <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) min_length_q <= i_cfg_data;
            if (i_in_valid && i_in_ready) expected_frames.push_back(predict_frame(i_in_item));
            if (i_out_valid && i_out_ready) begin
                if (expected_frames.size() == 0) begin
                    $error("result item with nothing expected: %h", i_out_item);
                    errs++;
                end else begin
                    want = expected_frames.pop_front();
                    if (want.out_direction !== i_out_item.out_direction) begin
                        $error("out_direction expected %h actual %h",
                               want.out_direction, i_out_item.out_direction);
                        errs++;
                    end
                    if (want.out_upward !== i_out_item.out_upward) begin
                        $error("out_upward expected %h actual %h",
                               want.out_upward, i_out_item.out_upward);
                        errs++;
                    end
                    if (want.direction_fell_back !== i_out_item.direction_fell_back) begin
                        $error("direction_fell_back expected %b actual %b",
                               want.direction_fell_back, i_out_item.direction_fell_back);
                        errs++;
                    end
                    if (want.upward_fell_back !== i_out_item.upward_fell_back) begin
                        $error("upward_fell_back expected %b actual %b",
                               want.upward_fell_back, i_out_item.upward_fell_back);
                        errs++;
                    end
                    if (want.upward_degenerate !== i_out_item.upward_degenerate) begin
                        $error("upward_degenerate expected %b actual %b",
                               want.upward_degenerate, i_out_item.upward_degenerate);
                        errs++;
                    end
                end
            end
            o_mismatches <= o_mismatches + errs;
            o_pending    <= expected_frames.size();
        end
    end

endmodule

>>> tb/orientation_frame_interpolator_test.sv
`timescale 1ns / 100ps
// Top of the orientation frame interpolator testbench: clock, reset, stimulus
// and verdict. Depends on ofi_pkg, the block and ofi_frame_checker.
module orientation_frame_interpolator_test;
    import ofi_pkg::*;

    // Pipeline depth at the default format, plus margin for the drain.
    localparam int DRAIN_CYCLES = 2 * FRACTION_BITS_DEFAULT + 87 + 20;
    localparam int ONE_Q14      = 16384;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    t_in_item                   in_item;
    logic                       out_valid;
    logic                       out_ready;
    t_out_item                  out_item;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [MIN_LENGTH_BITS-1:0] cfg_data;
    int                         mismatches;
    int                         pending;

    // Shared flags: stimulus asks, the receiver process acts.
    bit steady;
    bit hold_request;
    bit hold_taken;
    int hold_left;

    orientation_frame_interpolator DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    ofi_frame_checker frame_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (out_item),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("orientation_frame_interpolator verification failed");
        $finish;
    end

    // Receiver: random back-pressure, one long hold-off on request, none while steady.
    initial begin
        out_ready = 1'b0;
        hold_taken = 0;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                out_ready <= 1'b0;
            end else if (hold_request && !hold_taken) begin
                hold_taken = 1;
                hold_left = 4 * DRAIN_CYCLES;
                out_ready <= 1'b0;
            end else begin
                out_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 20);
            end
        end
    end

    function automatic logic [VEC_BITS-1:0] make_vec(int x, int y, int z);
        logic [VEC_BITS-1:0] r;
        r[15:0]  = x[15:0];
        r[31:16] = y[15:0];
        r[47:32] = z[15:0];
        return r;
    endfunction

    function automatic logic [VEC_BITS-1:0] negate_vec(logic [VEC_BITS-1:0] v);
        logic [VEC_BITS-1:0] r;
        for (int i = 0; i < 3; i++) r[i*16 +: 16] = -v[i*16 +: 16];
        return r;
    endfunction

    // Mostly vectors with each component in [-1, 1], with tiny, raw and axis-aligned ones mixed in.
    function automatic logic [VEC_BITS-1:0] random_vec();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 20) return VEC_BITS'({$urandom, $urandom});
        if (pick < 35) return make_vec($urandom_range(0, 8) - 4, $urandom_range(0, 8) - 4,
                                       $urandom_range(0, 8) - 4);
        if (pick < 45) return make_vec(($urandom_range(0, 1) ? ONE_Q14 : -ONE_Q14), 0, 0);
        return make_vec($urandom_range(0, 2 * ONE_Q14) - ONE_Q14,
                        $urandom_range(0, 2 * ONE_Q14) - ONE_Q14,
                        $urandom_range(0, 2 * ONE_Q14) - ONE_Q14);
    endfunction

    function automatic logic [BLEND_BITS-1:0] random_blend();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 10) return 16'd0;
        if (pick < 20) return BLEND_BITS'(BLEND_ONE);
        if (pick < 30) return BLEND_BITS'($urandom_range(BLEND_ONE + 1, 65535));
        return BLEND_BITS'($urandom_range(0, BLEND_ONE));
    endfunction

    function automatic t_in_item random_item();
        t_in_item it;
        int       pick;
        it.a_direction = random_vec();
        it.a_upward    = random_vec();
        it.b_direction = random_vec();
        it.b_upward    = random_vec();
        it.blend       = random_blend();
        pick = $urandom_range(0, 99);
        // Opposed frames near the midpoint drive the blend short.
        if (pick < 10) begin
            it.b_direction = negate_vec(it.a_direction);
            it.blend = BLEND_BITS'(16384 + $urandom_range(0, 4) - 2);
        end else if (pick < 20) begin
            it.b_upward = negate_vec(it.a_upward);
            it.blend = BLEND_BITS'(16384 + $urandom_range(0, 4) - 2);
        end else if (pick < 28) begin
            // Up along the direction makes the orthogonal part vanish.
            it.a_upward = it.a_direction;
            it.b_upward = it.b_direction;
        end
        return it;
    endfunction

    task automatic send_item(t_in_item it);
        if (!steady && $urandom_range(0, 99) < 20) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic send_frame(logic [VEC_BITS-1:0] ad, logic [VEC_BITS-1:0] au,
                              logic [VEC_BITS-1:0] bd, logic [VEC_BITS-1:0] bu,
                              logic [BLEND_BITS-1:0] f);
        t_in_item it;
        it.a_direction = ad;
        it.a_upward    = au;
        it.b_direction = bd;
        it.b_upward    = bu;
        it.blend       = f;
        send_item(it);
    endtask

    // Drop valid, drain the pipeline, then write min_length.
    task automatic write_min_length(logic [MIN_LENGTH_BITS-1:0] value);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [VEC_BITS-1:0]        ex, ey, ez, pmax, nmax;
        logic [MIN_LENGTH_BITS-1:0] settings [6];
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_item      = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        steady       = 0;
        hold_request = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        ex   = make_vec(ONE_Q14, 0, 0);
        ey   = make_vec(0, ONE_Q14, 0);
        ez   = make_vec(0, 0, ONE_Q14);
        pmax = make_vec(32767, 32767, 32767);
        nmax = make_vec(-32768, -32768, -32768);

        // Directed items under the reset threshold.
        send_frame(ex, ey, ez, ex, 16'd0);
        send_frame(ex, ey, ez, ex, BLEND_BITS'(BLEND_ONE));
        send_frame(ex, ey, ez, ex, 16'd16384);
        send_frame(ex, ey, ez, ex, 16'hFFFF);
        send_frame(ex, ey, ez, ex, BLEND_BITS'(BLEND_ONE + 1));
        send_frame(pmax, nmax, nmax, pmax, 16'd16384);
        send_frame(nmax, pmax, pmax, nmax, 16'd1);
        send_frame(pmax, pmax, pmax, pmax, 16'd32767);
        send_frame(nmax, nmax, nmax, nmax, 16'd0);
        send_frame('0, '0, '0, '0, 16'd16384);           // zero everywhere
        send_frame(ex, ey, negate_vec(ex), ey, 16'd16384); // direction cancels
        send_frame(ex, ey, ex, negate_vec(ey), 16'd16384); // up cancels
        send_frame('0, ey, '0, ey, 16'd9000);             // zero direction
        send_frame(ex, ex, ey, ey, 16'd12345);            // up along direction
        send_frame(ex, negate_vec(ex), ex, negate_vec(ex), 16'd0);
        send_frame(make_vec(1, 0, 0), ey, make_vec(-1, 0, 0), ez, 16'd16384);
        send_frame(make_vec(1, 1, 1), make_vec(-1, 1, 0), ex, ey, 16'd3);
        send_frame({48{1'b1}}, {48{1'b1}}, {48{1'b1}}, {48{1'b1}}, 16'd20000);
        send_frame(48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, 48'hAAAA_AAAA_AAAA,
                   48'h5555_5555_5555, 16'd777);

        // Random phases across thresholds; the second runs steady and the first gets
        // the long output hold-off.
        settings = '{16'd2, 16'd0, 16'hFFFF, 16'd16384, 16'd300, 16'd2};
        for (int p = 0; p < 6; p++) begin
            if (p > 0) write_min_length(p == 4 ? MIN_LENGTH_BITS'($urandom_range(1, 65534))
                                               : settings[p]);
            steady = (p == 1);
            for (int n = 0; n < 255; n++) begin
                if (p == 0 && n == 40) hold_request = 1;
                send_item(random_item());
            end
        end
        in_valid <= 1'b0;
        steady = 0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("orientation_frame_interpolator verification clean");
        else
            $display("orientation_frame_interpolator verification failed");
        $finish;
    end

endmodule
